### src/fnv_pkg.sv
package fnv_pkg;

  localparam int CAPACITY = 1024;
  localparam int MAX_KEY_LEN = 16;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int KPOS_W = $clog2(MAX_KEY_LEN);
  localparam int KLEN_W = $clog2(MAX_KEY_LEN + 1);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PROBE_W = $clog2(CAPACITY + 1);
  localparam int LG_MAX = (SLOT_W < 10) ? SLOT_W : 10;
  localparam int QDEPTH = 2;

  localparam logic [31:0] HASH_SEED = 32'd2166136261;
  localparam logic [31:0] HASH_MULT = 32'd16777619;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_DUP = 3'd1;
  localparam logic [2:0] ST_TAKEN = 3'd2;
  localparam logic [2:0] ST_FOUND = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;

  localparam logic REQ_ADD = 1'b0;

  typedef logic [MAX_KEY_LEN-1:0][7:0] key_t;

  typedef struct packed {
    logic req;
    logic overflow;
    logic [KLEN_W-1:0] len;
    key_t key;
    logic [31:0] hash;
    logic [31:0] value;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CMP, S_DONE, S_CLEAR
  } bstate_t;

endpackage

### src/fnv_front.sv
module fnv_front import fnv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] key_byte,
  input  logic [31:0] value_in,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  logic [31:0] hash;
  logic [31:0] hash_next;
  logic [KLEN_W-1:0] len;
  logic overflow;
  key_t key;
  logic [1:0] phase;
  logic [31:0] xored;

  job_t q [QDEPTH];
  logic [$clog2(QDEPTH+1)-1:0] count;
  logic wr_ptr, rd_ptr;
  logic push, pop;

  // Byte path: xor into the xored register, then multiply into the hash register.
  assign in_ready = (phase == 2'd0) && (count < QDEPTH[$bits(count)-1:0]);
  assign hash_next = xored * HASH_MULT;
  assign push = in_valid && in_ready && (key_byte == 8'd0);
  assign pop = job_valid && job_ready;
  assign job_valid = (count != '0);
  assign job = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= HASH_SEED;
      len <= '0;
      overflow <= 1'b0;
      phase <= 2'd0;
      count <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (phase == 2'd1) begin
        hash <= hash_next;
        phase <= 2'd0;
      end else if (in_valid && in_ready) begin
        if (key_byte != 8'd0) begin
          xored <= hash ^ {24'd0, key_byte};
          phase <= 2'd1;
          if (len < KLEN_W'(MAX_KEY_LEN)) begin
            key[len[KPOS_W-1:0]] <= key_byte;
            len <= len + 1'b1;
          end else begin
            overflow <= 1'b1;
          end
        end else begin
          q[wr_ptr] <= '{req: req_type, overflow: overflow, len: len, key: key,
                         hash: hash, value: value_in};
          wr_ptr <= ~wr_ptr;
          hash <= HASH_SEED;
          len <= '0;
          overflow <= 1'b0;
        end
      end
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### src/fnv_back.sv
module fnv_back import fnv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] slots_log2,
  input  logic       job_valid,
  output logic       job_ready,
  input  job_t       job,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [31:0] value_out,
  output logic [9:0] slot_index,
  output logic [10:0] entry_count
);

  localparam int ENT_W = MAX_KEY_LEN * 8 + KLEN_W + 32;

  logic [ENT_W-1:0] mem [CAPACITY];
  logic valid [CAPACITY];
  logic [ENT_W-1:0] rd_data;
  logic rd_valid;

  bstate_t state, state_next;
  job_t cur;
  logic [SLOT_W-1:0] mask, home, idx;
  logic [SLOT_W-1:0] clr_idx;
  logic [PROBE_W-1:0] probes;
  logic [CNT_W-1:0] tally;
  logic [3:0] lg;
  key_t e_key;
  logic [KLEN_W-1:0] e_len;
  logic [31:0] e_val;
  logic match;
  logic [MAX_KEY_LEN-1:0] bmatch;

  always_comb begin
    lg = slots_log2;
    if (lg < 4'd1) lg = 4'd1;
    if (lg > 4'(LG_MAX)) lg = 4'(LG_MAX);
    mask = SLOT_W'((32'd1 << lg) - 32'd1);
  end

  assign e_key = rd_data[ENT_W-1 -: MAX_KEY_LEN*8];
  assign e_len = rd_data[32 +: KLEN_W];
  assign e_val = rd_data[31:0];

  always_comb begin
    for (int i = 0; i < MAX_KEY_LEN; i++) begin
      bmatch[i] = (i >= cur.len) || (e_key[i] == cur.key[i]);
    end
    match = (e_len == cur.len) && (&bmatch);
  end

  assign job_ready = (state == S_IDLE);
  assign entry_count = 11'(tally);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_idx == SLOT_W'(CAPACITY - 1)) state_next = S_IDLE;
      S_IDLE: if (job_valid) state_next = S_READ;
      S_READ: state_next = S_CMP;
      S_CMP: state_next = S_DONE;
      S_DONE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (state == S_CMP && cur.req != REQ_ADD && !cur.overflow && rd_valid && !match &&
        (probes + 1'b1) < ({1'b0, mask} + 1'b1))
      state_next = S_READ;
  end

  always_comb begin
    out_valid = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_data <= mem[idx];
      rd_valid <= valid[idx];
    end
    if (state == S_IDLE && job_valid) cur <= job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      tally <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: begin
          valid[clr_idx] <= 1'b0;
          clr_idx <= clr_idx + 1'b1;
        end
        S_IDLE: if (job_valid) begin
          home <= job.hash[SLOT_W-1:0] & mask;
          idx <= job.hash[SLOT_W-1:0] & mask;
          probes <= '0;
        end
        S_CMP: begin
          value_out <= 32'd0;
          slot_index <= 10'(home);
          if (cur.overflow) begin
            status <= ST_TOO_LONG;
          end else if (cur.req == REQ_ADD) begin
            if (!rd_valid) begin
              mem[home] <= {cur.key, cur.len, cur.value};
              valid[home] <= 1'b1;
              tally <= tally + 1'b1;
              status <= ST_ADDED;
            end else begin
              status <= match ? ST_DUP : ST_TAKEN;
            end
          end else if (rd_valid && match) begin
            status <= ST_FOUND;
            value_out <= e_val;
            slot_index <= 10'(idx);
          end else begin
            status <= ST_NOT_FOUND;
            idx <= (idx + 1'b1) & mask;
            probes <= probes + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### src/fnv1a_hash_table_linear_probe.sv
// String-key hash table with FNV-1a hashing and linear probing. Send one key
// byte per item; a zero byte ends the key and yields one result. Each nonzero
// byte is xored into the hash, then multiplied by the 32-bit FNV prime;
// in_ready is low until the multiply is done. A terminator enters a
// two-deep queue; the back end takes it while idle, then per probed slot
// does a table read and a full key compare, then presents the result: an
// add probes once, a retrieve up to the configured slot count. After reset
// the back end clears its 1024-entry valid map before serving; key bytes
// are still taken and up to two terminators queue meanwhile.
module fnv1a_hash_table_linear_probe import fnv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  key_byte,
  input  logic [31:0] value_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] value_out,
  output logic [9:0]  slot_index,
  output logic [10:0] entry_count
);

  logic [3:0] slots_log2;
  logic job_valid, job_ready;
  job_t job;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {28'd0, slots_log2} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_log2 <= 4'd10;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      slots_log2 <= pwdata[3:0];
    end
  end

  fnv_front u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .key_byte, .value_in,
    .job_valid, .job_ready, .job
  );

  fnv_back u_back (
    .clk, .rst, .slots_log2, .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .status, .value_out, .slot_index, .entry_count
  );

endmodule
